// ===== hw/rtl/stdp_syn_pkg.sv =====
// ----------------------------------------------------------------------------
// stdp_syn_pkg
// Shared types, constants and codes for the stdp synapse trace update block.
// ----------------------------------------------------------------------------
package stdp_syn_pkg;

    // field and datapath widths
    localparam int unsigned VAL_W  = 32;  // q16.16 values
    localparam int unsigned TGT_W  = 31;  // targets and gains
    localparam int unsigned RATE_W = 25;  // q0.24 rates, one included
    localparam int unsigned A_W    = 33;  // multiplier operand a
    localparam int unsigned B_W    = 32;  // multiplier operand b
    localparam int unsigned P_W    = A_W + B_W;
    localparam int unsigned SAT_W  = 50;  // width of pre-saturation sums

    // apb register port
    localparam int unsigned CFG_AW = 5;
    localparam int unsigned CFG_DW = 32;

    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(25'h100_0000);
    localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sd65536;

    // register reset values
    localparam logic [TGT_W-1:0]  POST_TARGET_RST = 31'd65536;
    localparam logic [TGT_W-1:0]  PRE_TARGET_RST  = 31'd65536;
    localparam logic [TGT_W-1:0]  GAIN_PLUS_RST   = 31'd65536;
    localparam logic [TGT_W-1:0]  GAIN_MINUS_RST  = 31'd65536;
    localparam logic [RATE_W-1:0] POST_RATE_RST   = 25'd1677722;
    localparam logic [RATE_W-1:0] PRE_RATE_RST    = RATE_ONE;
    localparam logic [RATE_W-1:0] STEP_SCALE_RST  = 25'd16777;

    typedef enum logic [2:0] {
        REG_POST_TARGET = 3'd0,
        REG_PRE_TARGET  = 3'd1,
        REG_GAIN_PLUS   = 3'd2,
        REG_GAIN_MINUS  = 3'd3,
        REG_POST_RATE   = 3'd4,
        REG_PRE_RATE    = 3'd5,
        REG_STEP_SCALE  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [TGT_W-1:0]  post_target;
        logic [TGT_W-1:0]  pre_target;
        logic [TGT_W-1:0]  gain_plus;
        logic [TGT_W-1:0]  gain_minus;
        logic [RATE_W-1:0] post_rate;
        logic [RATE_W-1:0] pre_rate;
        logic [RATE_W-1:0] step_scale;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POST,
        S_PRE,
        S_GP,
        S_GM,
        S_DIFF,
        S_INC,
        S_ACC,
        S_INFL,
        S_WMUL,
        S_WOUT
    } t_state;

    typedef enum logic [2:0] {
        OP_POST,
        OP_PRE,
        OP_GP,
        OP_GM,
        OP_INC,
        OP_W
    } t_mul_op;

    typedef enum logic {
        RND_Q16,
        RND_Q24
    } t_rnd;

    // sequencer controls for the datapath and the shared multiplier
    typedef struct packed {
        logic    in_ready;
        logic    mul_en;
        t_mul_op op;
        t_rnd    rnd;
        logic    upd_post;
        logic    upd_pre;
        logic    ld_x;
        logic    ld_diff;
        logic    upd_acc;
        logic    ld_infl;
        logic    ld_out;
    } t_ctl;

endpackage

// ===== hw/rtl/stdp_syn_in_if.sv =====
// ----------------------------------------------------------------------------
// stdp_syn_in_if
// Input channel: one simulation tick per transaction.
// ----------------------------------------------------------------------------
interface stdp_syn_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    pre_pulse;
    logic                                    post_pulse;
    logic signed [stdp_syn_pkg::VAL_W-1:0]   weight_in;

    modport source (output valid, output pre_pulse, output post_pulse, output weight_in,
                    input ready);
    modport sink   (input valid, input pre_pulse, input post_pulse, input weight_in,
                    output ready);
endinterface

// ===== hw/rtl/stdp_syn_out_if.sv =====
// ----------------------------------------------------------------------------
// stdp_syn_out_if
// Output channel: modulated weight and influence per transaction.
// ----------------------------------------------------------------------------
interface stdp_syn_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [stdp_syn_pkg::VAL_W-1:0]   weight_out;
    logic signed [stdp_syn_pkg::VAL_W-1:0]   influence;

    modport source (output valid, output weight_out, output influence, input ready);
    modport sink   (input valid, input weight_out, input influence, output ready);
endinterface

// ===== hw/rtl/stdp_syn_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// stdp_syn_cfg_regs
// APB register file for targets, gains and q0.24 rates.
// ----------------------------------------------------------------------------
module stdp_syn_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [stdp_syn_pkg::CFG_AW-1:0]    paddr,
    input  logic [stdp_syn_pkg::CFG_DW-1:0]    pwdata,
    output logic [stdp_syn_pkg::CFG_DW-1:0]    prdata,
    output logic                               pready,
    output stdp_syn_pkg::t_cfg                 o_cfg
);
    import stdp_syn_pkg::*;

    t_cfg              r_cfg;
    logic              wr_en;
    t_reg_idx          idx;
    logic [TGT_W-1:0]  wr_v31;
    logic [RATE_W-1:0] wr_rate;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign wr_v31 = pwdata[TGT_W-1:0];
    // rates clamp to one when bit 24 of the write data is set; higher bits are ignored
    assign wr_rate = pwdata[RATE_W-1] ? RATE_ONE : pwdata[RATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.post_target <= POST_TARGET_RST;
            r_cfg.pre_target  <= PRE_TARGET_RST;
            r_cfg.gain_plus   <= GAIN_PLUS_RST;
            r_cfg.gain_minus  <= GAIN_MINUS_RST;
            r_cfg.post_rate   <= POST_RATE_RST;
            r_cfg.pre_rate    <= PRE_RATE_RST;
            r_cfg.step_scale  <= STEP_SCALE_RST;
        end else if (wr_en) begin
            case (idx)
                REG_POST_TARGET: r_cfg.post_target <= wr_v31;
                REG_PRE_TARGET:  r_cfg.pre_target  <= wr_v31;
                // zero gains are dropped
                REG_GAIN_PLUS: begin
                    if (wr_v31 != '0) r_cfg.gain_plus <= wr_v31;
                end
                REG_GAIN_MINUS: begin
                    if (wr_v31 != '0) r_cfg.gain_minus <= wr_v31;
                end
                REG_POST_RATE:   r_cfg.post_rate  <= wr_rate;
                REG_PRE_RATE:    r_cfg.pre_rate   <= wr_rate;
                REG_STEP_SCALE:  r_cfg.step_scale <= wr_rate;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_POST_TARGET: prdata = CFG_DW'(r_cfg.post_target);
            REG_PRE_TARGET:  prdata = CFG_DW'(r_cfg.pre_target);
            REG_GAIN_PLUS:   prdata = CFG_DW'(r_cfg.gain_plus);
            REG_GAIN_MINUS:  prdata = CFG_DW'(r_cfg.gain_minus);
            REG_POST_RATE:   prdata = CFG_DW'(r_cfg.post_rate);
            REG_PRE_RATE:    prdata = CFG_DW'(r_cfg.pre_rate);
            REG_STEP_SCALE:  prdata = CFG_DW'(r_cfg.step_scale);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/stdp_syn_mul_unit.sv =====
// ----------------------------------------------------------------------------
// stdp_syn_mul_unit
// Shared signed multiplier with rounding bias, registered product.
// ----------------------------------------------------------------------------
module stdp_syn_mul_unit (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [stdp_syn_pkg::A_W-1:0]    i_a,
    input  logic signed [stdp_syn_pkg::B_W-1:0]    i_b,
    input  stdp_syn_pkg::t_rnd                     i_rnd,
    output logic signed [stdp_syn_pkg::P_W-1:0]    o_prod
);
    import stdp_syn_pkg::*;

    // half an lsb of the target format, so a plain arithmetic shift rounds
    localparam logic signed [P_W-1:0] HALF_Q16 = P_W'(64'd32768);
    localparam logic signed [P_W-1:0] HALF_Q24 = P_W'(64'd8388608);

    logic signed [P_W-1:0] r_prod;
    logic signed [P_W-1:0] n_prod;
    logic signed [P_W-1:0] half;

    assign half   = (i_rnd == RND_Q24) ? HALF_Q24 : HALF_Q16;
    assign n_prod = P_W'(i_a) * P_W'(i_b) + half;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/stdp_synapse_trace_update.sv =====
// sequence: S_POST to S_WOUT; S_WOUT waits for a free output register, then loads it
// a new tick is taken only in S_IDLE; a ten-step sequencer shares one 33x32 multiplier
// the output register lets the next tick enter while the last result waits
// reset: synchronous active low; clears both traces, the accumulator and the sequencer,
// and loads the register defaults (targets and gains 1.0, rates 0.1, 1.0, 1/1000)
// ----------------------------------------------------------------------------
// stdp_synapse_trace_update
// Trace-based plasticity for one synapse: pre/post traces, difference
// accumulator and modulated output, computed on one shared multiplier.
// ----------------------------------------------------------------------------
module stdp_synapse_trace_update (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    stdp_syn_in_if.sink                        i_in_ch,
    stdp_syn_out_if.source                     o_out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [stdp_syn_pkg::CFG_AW-1:0]    paddr,
    input  logic [stdp_syn_pkg::CFG_DW-1:0]    pwdata,
    output logic [stdp_syn_pkg::CFG_DW-1:0]    prdata,
    output logic                               pready
);
    import stdp_syn_pkg::*;

    // saturate a wide signed sum to q16.16
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [VAL_W-1:0] res;
        if (v[SAT_W-1:VAL_W-1] == {(SAT_W-VAL_W+1){v[SAT_W-1]}}) begin
            res = v[VAL_W-1:0];
        end else if (v[SAT_W-1]) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;
    t_ctl   ctl;

    // latched transaction
    logic                    r_pre;
    logic                    r_post;
    logic signed [VAL_W-1:0] r_w;

    // architectural state
    logic signed [VAL_W-1:0] r_post_trace;
    logic signed [VAL_W-1:0] r_pre_trace;
    logic signed [VAL_W-1:0] r_acc;

    // intermediates
    logic signed [VAL_W-1:0] r_x;
    logic signed [A_W-1:0]   r_diff;
    logic signed [VAL_W-1:0] r_infl;

    // output register
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_w;
    logic signed [VAL_W-1:0] r_out_infl;

    logic                    in_acc;
    logic                    out_free;

    // shared multiplier
    logic signed [A_W-1:0]   mul_a;
    logic signed [B_W-1:0]   mul_b;
    logic signed [P_W-1:0]   mul_prod;
    logic signed [P_W-25:0]  q24;   // product with a q0.24 rate, rounded back to q16.16
    logic signed [P_W-17:0]  q16;   // product of two q16.16 values, rounded back to q16.16

    logic signed [SAT_W-1:0] post_sum;
    logic signed [SAT_W-1:0] pre_sum;
    logic signed [VAL_W-1:0] y_res;
    logic signed [VAL_W-1:0] w_res;

    stdp_syn_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    stdp_syn_mul_unit u_mul (
        .i_clk  (i_clk),
        .i_en   (ctl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_rnd  (ctl.rnd),
        .o_prod (mul_prod)
    );

    assign in_acc   = i_in_ch.valid & ctl.in_ready;
    assign out_free = !r_out_valid | o_out_ch.ready;

    // ------------------------------------------------------------------------
    // sequencer: at most one multiply issued per step, consumed the step after
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_POST;
            end
            S_POST: n_state = S_PRE;
            S_PRE:  n_state = S_GP;
            S_GP:   n_state = S_GM;
            S_GM:   n_state = S_DIFF;
            S_DIFF: n_state = S_INC;
            S_INC:  n_state = S_ACC;
            S_ACC:  n_state = S_INFL;
            S_INFL: n_state = S_WMUL;
            S_WMUL: n_state = S_WOUT;
            // hold here while the previous result has not been taken
            S_WOUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        ctl.op  = OP_POST;
        ctl.rnd = RND_Q24;
        case (r_state)
            S_IDLE: ctl.in_ready = 1'b1;
            // post trace product
            S_POST: begin
                ctl.mul_en = 1'b1;
                ctl.op     = OP_POST;
                ctl.rnd    = RND_Q24;
            end
            // pre trace product, post trace update
            S_PRE: begin
                ctl.mul_en   = 1'b1;
                ctl.op       = OP_PRE;
                ctl.rnd      = RND_Q24;
                ctl.upd_post = 1'b1;
            end
            // potentiation product, pre trace update
            S_GP: begin
                ctl.mul_en  = 1'b1;
                ctl.op      = OP_GP;
                ctl.rnd     = RND_Q16;
                ctl.upd_pre = 1'b1;
            end
            // depression product, latch potentiation term
            S_GM: begin
                ctl.mul_en = 1'b1;
                ctl.op     = OP_GM;
                ctl.rnd    = RND_Q16;
                ctl.ld_x   = 1'b1;
            end
            S_DIFF: ctl.ld_diff = 1'b1;
            // scale the difference by the step rate
            S_INC: begin
                ctl.mul_en = 1'b1;
                ctl.op     = OP_INC;
                ctl.rnd    = RND_Q24;
            end
            S_ACC:  ctl.upd_acc = 1'b1;
            S_INFL: ctl.ld_infl = 1'b1;
            // base weight times influence
            S_WMUL: begin
                ctl.mul_en = 1'b1;
                ctl.op     = OP_W;
                ctl.rnd    = RND_Q16;
            end
            S_WOUT: ctl.ld_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // multiplier operand select
    // ------------------------------------------------------------------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.op)
            // relax toward target on a pulse, else decay; sign applied on update
            OP_POST: begin
                mul_a = r_post ? ($signed({2'b00, cfg.post_target})
                                  - $signed({r_post_trace[VAL_W-1], r_post_trace}))
                               : $signed({r_post_trace[VAL_W-1], r_post_trace});
                mul_b = $signed(B_W'(cfg.post_rate));
            end
            OP_PRE: begin
                mul_a = r_pre ? ($signed({2'b00, cfg.pre_target})
                                 - $signed({r_pre_trace[VAL_W-1], r_pre_trace}))
                              : $signed({r_pre_trace[VAL_W-1], r_pre_trace});
                mul_b = $signed(B_W'(cfg.pre_rate));
            end
            OP_GP: begin
                mul_a = $signed({r_post_trace[VAL_W-1], r_post_trace});
                mul_b = $signed({1'b0, cfg.gain_plus});
            end
            OP_GM: begin
                mul_a = $signed({r_pre_trace[VAL_W-1], r_pre_trace});
                mul_b = $signed({1'b0, cfg.gain_minus});
            end
            OP_INC: begin
                mul_a = r_diff;
                mul_b = $signed(B_W'(cfg.step_scale));
            end
            OP_W: begin
                mul_a = $signed({r_w[VAL_W-1], r_w});
                mul_b = r_infl;
            end
            default: ;
        endcase
    end

    // rounding bias is already in the product, so these are plain shifts
    assign q24 = mul_prod[P_W-1:24];
    assign q16 = mul_prod[P_W-1:16];

    // decay subtracts the rounded product, relaxation adds it
    assign post_sum = r_post ? (SAT_W'(r_post_trace) + SAT_W'(q24))
                             : (SAT_W'(r_post_trace) - SAT_W'(q24));
    assign pre_sum  = r_pre  ? (SAT_W'(r_pre_trace) + SAT_W'(q24))
                             : (SAT_W'(r_pre_trace) - SAT_W'(q24));

    assign y_res = r_pre ? sat32(SAT_W'(q16)) : '0;
    // negative influence gates the output to zero
    assign w_res = r_infl[VAL_W-1] ? '0 : sat32(SAT_W'(q16));

    // ------------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post_trace <= '0;
            r_pre_trace  <= '0;
            r_acc        <= '0;
        end else begin
            if (ctl.upd_post) r_post_trace <= sat32(post_sum);
            if (ctl.upd_pre)  r_pre_trace  <= sat32(pre_sum);
            if (ctl.upd_acc)  r_acc        <= sat32(SAT_W'(r_acc) + SAT_W'(q24));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pre  <= i_in_ch.pre_pulse;
            r_post <= i_in_ch.post_pulse;
            r_w    <= i_in_ch.weight_in;
        end
        if (ctl.ld_x) begin
            r_x <= r_post ? sat32(SAT_W'(q16)) : '0;
        end
        if (ctl.ld_diff) begin
            r_diff <= A_W'(r_x) - A_W'(y_res);
        end
        if (ctl.ld_infl) begin
            r_infl <= sat32(SAT_W'(ONE_Q16) - SAT_W'(r_acc));
        end
        if (ctl.ld_out) begin
            r_out_w    <= w_res;
            r_out_infl <= r_infl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in_ch.ready       = ctl.in_ready;
    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.weight_out = r_out_w;
    assign o_out_ch.influence  = r_out_infl;

`ifndef ASSERT_OFF
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_IDLE) && !r_out_valid)
        else $error("sequencer or output register not cleared by reset");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> (r_state == S_POST))
        else $error("accepted transaction did not start the sequence");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_WOUT))
        else $error("result appeared outside the final step");

    a_neg_infl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.influence[31]) |-> (o_out_ch.weight_out == '0))
        else $error("negative influence with nonzero weight output");
`endif

endmodule
